>>> sv/mavg_pkg.sv
// Shared types, constants and codes of the moving average window block.
`default_nettype none
package mavg_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACTION_W        = 2;
  localparam int SAMPLE_W        = 16;
  localparam int COUNT_W         = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_RESIZE = 2'd2
  } mavg_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SUB,
    ST_WRITE,
    ST_FINISH,
    ST_DIVWAIT,
    ST_DONE
  } mavg_state_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]       new_window;
  } mavg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       full_res;
    logic [COUNT_W-1:0]         remaining;
    logic [COUNT_W-1:0]         window_now;
  } mavg_out_t;

endpackage
`default_nettype wire

>>> sv/moving_average_window.sv
// Boxcar moving average filter over a resizable window of stored samples.
//
// Usage: a request on the input channel (in_valid, in_stall, in_data) carries an
// action: push a sample, clear the window, or set a new window size (zero is
// taken as one, sizes above DEPTH as DEPTH). Every request gives exactly one
// result on the output channel (out_valid, out_stall, out_data): the average
// (running sum divided by the window, truncated toward zero, zero while the
// window is not full), the full flag, the samples still needed and the window.
// A request passes EXEC and then FINISH; a push writes its sample in WRITE, and a
// push into a full window first reads and subtracts the oldest sample (READ, SUB).
// A request that leaves the window full then waits in DIVWAIT on the serial
// divider, which produces one quotient bit per cycle; the running sum is SUM_W =
// SAMPLE_BITS + clog2(DEPTH + 1) bits wide (25 at the defaults). A shrinking resize
// reads and subtracts every sample dropped, through the single read port of the
// ring. One request is in work at a time; in_stall is high until its result is in
// the output register, and the next request can be taken in the following cycle.
// Reset empties the window, zeroes the sum and sets the window to DEPTH.
// A finished result waits in the output register while out_stall is high, and
// the next request is taken meanwhile; it completes once that register frees.
`default_nettype none
module moving_average_window #(
  parameter int DEPTH       = mavg_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mavg_pkg::mavg_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mavg_pkg::mavg_out_t     out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > mavg_pkg::COUNT_W) ? CNT_W : mavg_pkg::COUNT_W;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  mavg_pkg::mavg_state_t state_r, state_nxt;
  logic [mavg_pkg::ACTION_W-1:0] act_r, act_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [CNT_W-1:0]              wreq_r, wreq_nxt;
  logic [PTR_W-1:0]              newest_r, newest_nxt;
  logic [PTR_W-1:0]              oldest_r, oldest_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [CNT_W-1:0]              win_r, win_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [mavg_pkg::SAMPLE_W-1:0] avg_r, avg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mavg_pkg::mavg_out_t           out_data_r, out_data_nxt;

  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [CMP_W-1:0]              wreq_wide;
  logic [CNT_W-1:0]              wreq_in;
  logic [PTR_W-1:0]              newest_inc;
  logic [PTR_W-1:0]              oldest_inc;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic                          wr_en;
  logic                          div_start;
  logic                          div_done;
  logic signed [SUM_W-1:0]       div_quo;
  logic                          full_now;

  if (SAMPLE_BITS <= mavg_pkg::SAMPLE_W) begin : g_narrow
    assign sample_in = $signed(in_data.sample[SAMPLE_BITS-1:0]);
  end else begin : g_wide
    assign sample_in = $signed(SAMPLE_BITS'($unsigned(in_data.sample)));
  end

  assign wreq_wide  = CMP_W'(in_data.new_window);
  assign wreq_in    = (wreq_wide == '0) ? CNT_W'(1) :
                      (wreq_wide > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(wreq_wide);
  assign newest_inc = (newest_r == PTR_W'(DEPTH - 1)) ? '0 : newest_r + 1'b1;
  assign oldest_inc = (oldest_r == PTR_W'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign full_now   = (fill_r == win_r);

  mavg_ring #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS),
    .PTR_W  (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (newest_inc),
    .wr_data (sample_r),
    .rd_addr (oldest_r),
    .rd_data (rd_data)
  );

  mavg_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    sample_nxt    = sample_r;
    wreq_nxt      = wreq_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    fill_nxt      = fill_r;
    win_nxt       = win_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    in_stall      = (state_r != mavg_pkg::ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mavg_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_data.action;
          sample_nxt = sample_in;
          wreq_nxt   = wreq_in;
          state_nxt  = mavg_pkg::ST_EXEC;
        end
      end
      mavg_pkg::ST_EXEC: begin
        case (act_r)
          mavg_pkg::ACT_PUSH: begin
            state_nxt = full_now ? mavg_pkg::ST_READ : mavg_pkg::ST_WRITE;
          end
          mavg_pkg::ACT_CLEAR: begin
            fill_nxt  = '0;
            sum_nxt   = '0;
            state_nxt = mavg_pkg::ST_FINISH;
          end
          mavg_pkg::ACT_RESIZE: begin
            if (fill_r > wreq_r) begin
              state_nxt = mavg_pkg::ST_READ;
            end else begin
              win_nxt   = wreq_r;
              state_nxt = mavg_pkg::ST_FINISH;
            end
          end
          default: begin
            state_nxt = mavg_pkg::ST_FINISH;
          end
        endcase
      end
      mavg_pkg::ST_READ: begin
        state_nxt = mavg_pkg::ST_SUB;
      end
      mavg_pkg::ST_SUB: begin
        sum_nxt    = sum_r - SUM_W'($signed(rd_data));
        fill_nxt   = fill_r - 1'b1;
        oldest_nxt = oldest_inc;
        if (act_r == mavg_pkg::ACT_PUSH) begin
          state_nxt = mavg_pkg::ST_WRITE;
        end else if (fill_nxt > wreq_r) begin
          state_nxt = mavg_pkg::ST_READ;
        end else begin
          win_nxt   = wreq_r;
          state_nxt = mavg_pkg::ST_FINISH;
        end
      end
      mavg_pkg::ST_WRITE: begin
        wr_en      = 1'b1;
        newest_nxt = newest_inc;
        sum_nxt    = sum_r + SUM_W'(sample_r);
        fill_nxt   = fill_r + 1'b1;
        if (fill_r == '0) begin
          oldest_nxt = newest_inc;
        end
        state_nxt = mavg_pkg::ST_FINISH;
      end
      mavg_pkg::ST_FINISH: begin
        if (full_now) begin
          div_start = 1'b1;
          state_nxt = mavg_pkg::ST_DIVWAIT;
        end else begin
          avg_nxt   = '0;
          state_nxt = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DIVWAIT: begin
        if (div_done) begin
          avg_nxt   = mavg_pkg::SAMPLE_W'(div_quo);
          state_nxt = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.average    = avg_r;
          out_data_nxt.full_res   = full_now;
          out_data_nxt.remaining  = mavg_pkg::COUNT_W'(win_r - fill_r);
          out_data_nxt.window_now = mavg_pkg::COUNT_W'(win_r);
          state_nxt               = mavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mavg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mavg_pkg::ST_IDLE;
      newest_r    <= '0;
      oldest_r    <= '0;
      fill_r      <= '0;
      win_r       <= CNT_W'(DEPTH);
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      win_r       <= win_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    sample_r   <= sample_nxt;
    wreq_r     <= wreq_nxt;
    avg_r      <= avg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("Fill count exceeds the window size.");

  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != '0) && (win_r <= CNT_W'(DEPTH)))
    else $error("Window size is outside one to DEPTH.");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0))
    else $error("Running sum is not zero with an empty window.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mavg_pkg::ST_DONE))
    else $error("A result appeared without a finished request.");
`endif

endmodule
`default_nettype wire

>>> sv/mavg_ring.sv
// Sample ring memory with one write port and one registered read port.
`default_nettype none
module mavg_ring #(
  parameter int DEPTH  = mavg_pkg::DEPTH_DEF,
  parameter int DATA_W = mavg_pkg::SAMPLE_BITS_DEF,
  parameter int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [PTR_W-1:0]  wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [PTR_W-1:0]  rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> sv/mavg_div.sv
// Serial restoring divider: signed dividend by unsigned divisor, one quotient bit a cycle.
`default_nettype none
module mavg_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [DIVIDEND_W-1:0] dividend,
  input  wire logic        [DIVISOR_W-1:0]  divisor,
  output logic                              done,
  output logic signed      [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    ge       = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(DIVIDEND_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[DIVIDEND_W-1];
      quo_nxt  = dividend[DIVIDEND_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
    end else if (busy_r) begin
      rem_nxt = ge ? DIVISOR_W'(rem_diff) : DIVISOR_W'(rem_sh);
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule
`default_nettype wire
